// ===== rtl/wsp_pkg.sv =====
package wsp_pkg;

   // default depth of the token queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [6:0] MASK_ALL = 7'h7F;
   localparam logic [23:0] NAME_ALL = 24'h616C6C;
   localparam logic [2:0] NO_DAY = 3'd7;

   // three-letter names, first letter in the top byte, index is the weekday
   localparam logic [23:0] DAY_NAMES [7] = '{
      24'h73756E, // sun
      24'h6D6F6E, // mon
      24'h747565, // tue
      24'h776564, // wed
      24'h746875, // thu
      24'h667269, // fri
      24'h736174  // sat
   };

   // character class found by the front end
   typedef enum logic [2:0] {
      TK_LETTER,
      TK_SPACE,
      TK_COMMA,
      TK_DASH,
      TK_END,
      TK_OTHER
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   letter;
   } token_type;

   // weekday index of a name, NO_DAY if it is not a weekday
   function automatic logic [2:0] day_of(input logic [23:0] name);
      logic [2:0] idx;
      idx = NO_DAY;
      for (int i = 0; i < 7; i++) begin
         if (DAY_NAMES[i] == name) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   // days from f up to t, wrapping past saturday when t is below f
   function automatic logic [6:0] range_mask(input logic [2:0] f, input logic [2:0] t);
      logic [6:0] up;
      logic [6:0] dn;
      up = MASK_ALL << f;
      dn = MASK_ALL >> (3'd6 - t);
      return (f <= t) ? (up & dn) : (up | dn);
   endfunction

endpackage

// ===== rtl/wsp_if.sv =====
interface wsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_end;

   modport source (output valid, output ch, output is_end, input ready);
   modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface wsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] days;
   logic       ok;

   modport source (output valid, output days, output ok, input ready);
   modport sink (input valid, input days, input ok, output ready);
endinterface

// ===== rtl/wsp_classify.sv =====
module wsp_classify (
   wsp_req_if.sink            req_bus,
   input  logic               queue_full,
   output logic               push,
   output wsp_pkg::token_type push_token
);
   import wsp_pkg::*;

   logic [7:0] c;
   logic       upper;
   logic       lower_c;

   // take a beat whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign push = req_bus.valid && !queue_full;

   assign c = req_bus.ch;
   assign upper = c inside {[8'h41:8'h5A]};
   assign lower_c = c inside {[8'h61:8'h7A]};

   // classify the character and fold upper case
   always_comb begin
      push_token.letter = upper ? (c | 8'h20) : c;
      if (req_bus.is_end || c == CHAR_NUL) begin
         push_token.kind = TK_END;
      end else if (upper || lower_c) begin
         push_token.kind = TK_LETTER;
      end else if (c == CHAR_SPACE) begin
         push_token.kind = TK_SPACE;
      end else if (c == CHAR_COMMA) begin
         push_token.kind = TK_COMMA;
      end else if (c == CHAR_DASH) begin
         push_token.kind = TK_DASH;
      end else begin
         push_token.kind = TK_OTHER;
      end
   end

endmodule

// ===== rtl/wsp_queue.sv =====
module wsp_queue #(
   parameter int unsigned DEPTH = wsp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsp_pkg::token_type push_token,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output wsp_pkg::token_type head
);
   import wsp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   token_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ===== rtl/wsp_parse.sv =====
module wsp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  wsp_pkg::token_type tok,
   output logic               pop,
   wsp_rsp_if.source          rsp_bus
);
   import wsp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_DASH,
      ST_SECOND,
      ST_FAIL
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  count_ff, count_in;
   logic [23:0] first_ff, first_in;
   logic [23:0] second_ff, second_in;
   logic [6:0]  mask_ff, mask_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_mask_ff, rsp_mask_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        out_free;
   logic        is_end;
   logic [23:0] to_name;
   logic [2:0]  from_day;
   logic [2:0]  to_day;
   logic        from_all;
   logic        term_good;
   logic [6:0]  term_mask;
   logic        full_name;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign is_end   = (tok.kind == TK_END);
   assign pop      = tok_valid && (!is_end || out_free);
   assign full_name = (count_ff == 2'd3);

   // term closing: lookup of both names and the range mask
   assign to_name   = (state_ff == ST_SECOND) ? second_ff : first_ff;
   assign from_day  = day_of(first_ff);
   assign to_day    = day_of(to_name);
   assign from_all  = (first_ff == NAME_ALL);
   assign term_good = from_all || (from_day != NO_DAY && to_day != NO_DAY);
   assign term_mask = from_all ? MASK_ALL : (mask_ff | range_mask(from_day, to_day));

   // parser next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_ok_in    = rsp_ok_ff;

      if (pop) begin
         if (is_end) begin
            // end of string: emit the result beat and start over
            rsp_valid_in = 1'b1;
            rsp_ok_in    = full_name && (state_ff inside {ST_FIRST, ST_SECOND})
                           && term_good;
            rsp_mask_in  = rsp_ok_in ? term_mask : '0;
            state_in     = ST_IDLE;
            count_in     = '0;
            mask_in      = '0;
         end else begin
            case (state_ff)
               ST_IDLE, ST_DASH: begin
                  if (tok.kind == TK_LETTER) begin
                     count_in = 2'd1;
                     if (state_ff == ST_IDLE) begin
                        first_in = {first_ff[15:0], tok.letter};
                        state_in = ST_FIRST;
                     end else begin
                        second_in = {second_ff[15:0], tok.letter};
                        state_in  = ST_SECOND;
                     end
                  end else if (tok.kind != TK_SPACE) begin
                     state_in = ST_FAIL;
                  end
               end
               ST_FIRST, ST_SECOND: begin
                  if (tok.kind == TK_LETTER) begin
                     // letters past the third are dropped
                     if (!full_name) begin
                        count_in = count_ff + 2'd1;
                        if (state_ff == ST_FIRST) begin
                           first_in = {first_ff[15:0], tok.letter};
                        end else begin
                           second_in = {second_ff[15:0], tok.letter};
                        end
                     end
                  end else if (!full_name) begin
                     state_in = ST_FAIL;
                  end else if (tok.kind == TK_DASH && state_ff == ST_FIRST) begin
                     count_in = '0;
                     state_in = ST_DASH;
                  end else if (tok.kind == TK_COMMA) begin
                     if (term_good) begin
                        mask_in  = term_mask;
                        count_in = '0;
                        state_in = ST_IDLE;
                     end else begin
                        state_in = ST_FAIL;
                     end
                  end else if (tok.kind != TK_SPACE) begin
                     state_in = ST_FAIL;
                  end
               end
               ST_FAIL: begin
                  state_in = ST_FAIL;
               end
               default: begin
                  state_in = ST_FAIL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff    <= first_in;
      second_ff   <= second_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.days  = rsp_mask_ff;
   assign rsp_bus.ok    = rsp_ok_ff;

endmodule

// ===== rtl/weekday_spec_parser.sv =====
// result: when the parser pops the end token, the result beat is written
//    into the output register; tokens ahead of it in the queue are popped first
// throughput: one character per cycle while the queue has room
// a result waiting in the output register stalls only end-of-string tokens
// reset: synchronous, active high; clears parser state, queue and output valid
module weekday_spec_parser #(
   parameter int unsigned QueueDepth = wsp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   wsp_req_if.sink    req_bus,
   wsp_rsp_if.source  rsp_bus
);
   import wsp_pkg::*;

   logic      push;
   token_type push_token;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;
   token_type head;

   // front: classify characters into tokens
   wsp_classify u_classify (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   // token queue between front and back
   wsp_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // back: parser state machine and result register
   wsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!queue_empty),
      .tok       (head),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
